// ----- sv/bsl_pkg.sv -----
// ----------------------------------------------------------------------------
// bsl_pkg - shared types and constants of the byte stream lexer
// Byte classes passed from the front to the back, token kind codes, the
// result record and the byte classifier.
// ----------------------------------------------------------------------------
package bsl_pkg;

  localparam int unsigned KIND_W  = 5;
  localparam int unsigned FIELD_W = 16;

  // Token kind codes
  localparam logic [KIND_W-1:0] K_NEWLINE  = 5'd0;
  localparam logic [KIND_W-1:0] K_SPACE    = 5'd1;
  localparam logic [KIND_W-1:0] K_TAB      = 5'd2;
  localparam logic [KIND_W-1:0] K_STRING   = 5'd3;
  localparam logic [KIND_W-1:0] K_REGEX    = 5'd4;
  localparam logic [KIND_W-1:0] K_INTEGER  = 5'd5;
  localparam logic [KIND_W-1:0] K_LPAREN   = 5'd6;
  localparam logic [KIND_W-1:0] K_RPAREN   = 5'd7;
  localparam logic [KIND_W-1:0] K_LESS     = 5'd8;
  localparam logic [KIND_W-1:0] K_DLESS    = 5'd9;
  localparam logic [KIND_W-1:0] K_GREATER  = 5'd10;
  localparam logic [KIND_W-1:0] K_DGREATER = 5'd11;
  localparam logic [KIND_W-1:0] K_COLON    = 5'd12;
  localparam logic [KIND_W-1:0] K_POUND    = 5'd13;
  localparam logic [KIND_W-1:0] K_OR       = 5'd14;
  localparam logic [KIND_W-1:0] K_EOF      = 5'd15;
  localparam logic [KIND_W-1:0] K_ERROR    = 5'd16;

  // Characters the lexer recognizes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_POUND   = 8'h23;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_BAR     = 8'h7C;

  typedef enum logic [3:0] {
    C_NUL,
    C_NEWLINE,
    C_SPACE,
    C_TAB,
    C_COLON,
    C_POUND,
    C_LPAREN,
    C_RPAREN,
    C_BAR,
    C_DQUOTE,
    C_SQUOTE,
    C_LESS,
    C_GREATER,
    C_DIGIT,
    C_BSLASH,
    C_OTHER
  } byte_class_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] column;
    logic               last;
  } result_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    case (b)
      CH_NUL:    c = C_NUL;
      CH_NL:     c = C_NEWLINE;
      CH_SPACE:  c = C_SPACE;
      CH_TAB:    c = C_TAB;
      CH_COLON:  c = C_COLON;
      CH_POUND:  c = C_POUND;
      CH_LPAREN: c = C_LPAREN;
      CH_RPAREN: c = C_RPAREN;
      CH_BAR:    c = C_BAR;
      CH_DQUOTE: c = C_DQUOTE;
      CH_SQUOTE: c = C_SQUOTE;
      CH_LT:     c = C_LESS;
      CH_GT:     c = C_GREATER;
      CH_BSLASH: c = C_BSLASH;
      default: begin
        if (b >= CH_ZERO && b <= CH_NINE) c = C_DIGIT;
        else c = C_OTHER;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- sv/byte_stream_lexer.sv -----
// ----------------------------------------------------------------------------
// byte_stream_lexer - streaming tokenizer for zero-terminated text
// Classifies text bytes into tokens and reports kind, length and start
// position of each token, with error recovery up to the end of text.
// ----------------------------------------------------------------------------
// Accepts one text byte per cycle and delivers one result beat per cycle while
// out_ready is high. A byte that closes a digit run or a lone < or > and also
// starts a token of its own gives two results, and the two-slot result buffer
// then holds the input until a slot drains; every other byte gives zero or one
// result at full rate. A byte's first result passes the queue register, then
// the result buffer. Position and length counters are COUNTER_BITS wide,
// saturate, and are reported clamped to 16 bits. A zero byte ends the text
// (eof, error for an open string or regex, none after an unknown byte) and
// the position returns to line 1, column 1. No clearing pass after reset.
// ----------------------------------------------------------------------------
module byte_stream_lexer #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_token_length,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic        out_last_in_run
);

  logic                 push_valid, push_ready;
  bsl_pkg::byte_class_t push_class;
  logic                 q_valid, q_ready;
  bsl_pkg::byte_class_t q_class;
  bsl_pkg::result_t     result;

  bsl_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_class   (push_class)
  );

  bsl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_class (push_class),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_class  (q_class)
  );

  bsl_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_class  (q_class),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (result)
  );

  assign out_token_kind   = result.kind;
  assign out_token_length = result.length;
  assign out_start_line   = result.line;
  assign out_start_column = result.column;
  assign out_last_in_run  = result.last;

`ifndef ASSERT_OFF
  // the back only takes a byte when its result buffer drains empty
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |-> (!out_valid || out_ready))
    else $error("byte taken while result buffer still occupied");

  // input stalls only when the queue holds bytes
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("input stalled with empty queue");

  // end of text carries no length
  a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind == bsl_pkg::K_EOF) |-> (out_token_length == 16'd0))
    else $error("eof result with nonzero length");
`endif

endmodule

// ----- sv/bsl_front.sv -----
// ----------------------------------------------------------------------------
// bsl_front - input side of the byte stream lexer
// Takes text byte beats and reduces each byte to its lexical class before
// it enters the queue toward the back end.
// ----------------------------------------------------------------------------
module bsl_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_text_byte,
  output logic                 push_valid,
  input  logic                 push_ready,
  output bsl_pkg::byte_class_t push_class
);

  assign push_valid = in_valid;
  assign in_ready   = push_ready;
  assign push_class = bsl_pkg::classify(in_text_byte);

endmodule

// ----- sv/bsl_queue.sv -----
// ----------------------------------------------------------------------------
// bsl_queue - two-entry queue of classified bytes
// Decouples the front from the back so that either side can stall alone.
// ----------------------------------------------------------------------------
module bsl_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  bsl_pkg::byte_class_t push_class,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output bsl_pkg::byte_class_t pop_class
);

  localparam int unsigned DEPTH = 2;

  bsl_pkg::byte_class_t entry_r [DEPTH];
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  logic [1:0]           count_r;
  logic [1:0]           count_nxt;
  logic                 push;
  logic                 pop;

  assign push_ready = (count_r != 2'(DEPTH));
  assign pop_valid  = (count_r != 2'd0);
  assign pop_class  = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        entry_r[wr_ptr_r] <= push_class;
        wr_ptr_r          <= ~wr_ptr_r;
      end
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- sv/bsl_back.sv -----
// ----------------------------------------------------------------------------
// bsl_back - lexer state machine and result buffer
// Consumes one classified byte per cycle as room allows, tracks token mode
// and position counters, stages up to two results per byte for output.
// ----------------------------------------------------------------------------
module bsl_back #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  bsl_pkg::byte_class_t pop_class,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bsl_pkg::result_t     out_result
);

  localparam int unsigned CW = COUNTER_BITS;

  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [2:0] {
    M_START,
    M_STRING,
    M_ESCAPE,
    M_REGEX,
    M_INTEGER,
    M_LESS,
    M_GREATER,
    M_DROP
  } mode_t;

  localparam cnt_t CNT_ONE = CW'(1);

  mode_t mode_r, mode_nxt;
  cnt_t  len_r, len_nxt;
  cnt_t  line_r, line_nxt;
  cnt_t  col_r, col_nxt;
  cnt_t  tok_line_r, tok_line_nxt;
  cnt_t  tok_col_r, tok_col_nxt;

  bsl_pkg::result_t slot0_r, slot1_r;
  logic [1:0]       cnt_r;

  bsl_pkg::result_t r0, r1;
  logic [1:0]       n_res;
  logic             pop;
  logic             drain;

  // start-of-token outcome for the current byte
  logic             sb_emit;
  bsl_pkg::result_t sb_res;
  mode_t            sb_mode;
  cnt_t             sb_len, sb_line, sb_col, sb_tok_line, sb_tok_col;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == {CW{1'b1}}) ? v : v + CNT_ONE;
  endfunction

  function automatic logic [15:0] clamp16(input cnt_t v);
    logic [31:0] ext;
    ext = 32'(v);
    return (ext > 32'h0000_FFFF) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic bsl_pkg::result_t mk(input logic [4:0] kind, input cnt_t len,
                                          input cnt_t line, input cnt_t col);
    bsl_pkg::result_t r;
    r.kind   = kind;
    r.length = clamp16(len);
    r.line   = clamp16(line);
    r.column = clamp16(col);
    r.last   = 1'b0;
    return r;
  endfunction

  assign drain      = out_valid && out_ready;
  assign pop_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign pop        = pop_valid && pop_ready;
  assign out_valid  = (cnt_r != 2'd0);
  assign out_result = slot0_r;

  always_comb begin
    sb_emit     = 1'b1;
    sb_res      = mk(bsl_pkg::K_ERROR, CNT_ONE, line_r, col_r);
    sb_mode     = M_START;
    sb_len      = len_r;
    sb_line     = line_r;
    sb_col      = sat_inc(col_r);
    sb_tok_line = tok_line_r;
    sb_tok_col  = tok_col_r;
    case (pop_class)
      bsl_pkg::C_NUL: begin
        sb_res      = mk(bsl_pkg::K_EOF, '0, line_r, col_r);
        sb_len      = '0;
        sb_line     = CNT_ONE;
        sb_col      = CNT_ONE;
        sb_tok_line = CNT_ONE;
        sb_tok_col  = CNT_ONE;
      end
      bsl_pkg::C_NEWLINE: begin
        sb_res  = mk(bsl_pkg::K_NEWLINE, CNT_ONE, line_r, col_r);
        sb_line = sat_inc(line_r);
        sb_col  = CNT_ONE;
      end
      bsl_pkg::C_SPACE:  sb_res = mk(bsl_pkg::K_SPACE, CNT_ONE, line_r, col_r);
      bsl_pkg::C_TAB:    sb_res = mk(bsl_pkg::K_TAB, CNT_ONE, line_r, col_r);
      bsl_pkg::C_COLON:  sb_res = mk(bsl_pkg::K_COLON, CNT_ONE, line_r, col_r);
      bsl_pkg::C_POUND:  sb_res = mk(bsl_pkg::K_POUND, CNT_ONE, line_r, col_r);
      bsl_pkg::C_LPAREN: sb_res = mk(bsl_pkg::K_LPAREN, CNT_ONE, line_r, col_r);
      bsl_pkg::C_RPAREN: sb_res = mk(bsl_pkg::K_RPAREN, CNT_ONE, line_r, col_r);
      bsl_pkg::C_BAR:    sb_res = mk(bsl_pkg::K_OR, CNT_ONE, line_r, col_r);
      bsl_pkg::C_DQUOTE, bsl_pkg::C_SQUOTE, bsl_pkg::C_LESS, bsl_pkg::C_GREATER,
      bsl_pkg::C_DIGIT: begin
        sb_emit     = 1'b0;
        sb_len      = CNT_ONE;
        sb_tok_line = line_r;
        sb_tok_col  = col_r;
        case (pop_class)
          bsl_pkg::C_DQUOTE:  sb_mode = M_STRING;
          bsl_pkg::C_SQUOTE:  sb_mode = M_REGEX;
          bsl_pkg::C_LESS:    sb_mode = M_LESS;
          bsl_pkg::C_GREATER: sb_mode = M_GREATER;
          default:            sb_mode = M_INTEGER;
        endcase
      end
      default: begin
        // unknown byte: report it, then drop up to end of text
        sb_mode = M_DROP;
        sb_col  = col_r;
      end
    endcase
  end

  always_comb begin
    mode_nxt     = mode_r;
    len_nxt      = len_r;
    line_nxt     = line_r;
    col_nxt      = col_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    r0           = sb_res;
    r1           = sb_res;
    n_res        = 2'd0;
    case (mode_r)
      M_STRING, M_ESCAPE, M_REGEX: begin
        if (pop_class == bsl_pkg::C_NUL) begin
          // unterminated: error at token start, then a fresh text
          r0           = mk(bsl_pkg::K_ERROR, len_r, tok_line_r, tok_col_r);
          n_res        = 2'd1;
          mode_nxt     = M_START;
          len_nxt      = '0;
          line_nxt     = CNT_ONE;
          col_nxt      = CNT_ONE;
          tok_line_nxt = CNT_ONE;
          tok_col_nxt  = CNT_ONE;
        end else begin
          len_nxt = sat_inc(len_r);
          col_nxt = sat_inc(col_r);
          if (mode_r == M_ESCAPE) begin
            mode_nxt = M_STRING;
          end else if (mode_r == M_STRING && pop_class == bsl_pkg::C_DQUOTE) begin
            r0       = mk(bsl_pkg::K_STRING, sat_inc(len_r), tok_line_r, tok_col_r);
            n_res    = 2'd1;
            mode_nxt = M_START;
          end else if (mode_r == M_STRING && pop_class == bsl_pkg::C_BSLASH) begin
            mode_nxt = M_ESCAPE;
          end else if (mode_r == M_REGEX && pop_class == bsl_pkg::C_SQUOTE) begin
            r0       = mk(bsl_pkg::K_REGEX, sat_inc(len_r), tok_line_r, tok_col_r);
            n_res    = 2'd1;
            mode_nxt = M_START;
          end
        end
      end
      M_INTEGER, M_LESS, M_GREATER: begin
        if (mode_r == M_INTEGER && pop_class == bsl_pkg::C_DIGIT) begin
          len_nxt = sat_inc(len_r);
          col_nxt = sat_inc(col_r);
        end else if ((mode_r == M_LESS && pop_class == bsl_pkg::C_LESS) ||
                     (mode_r == M_GREATER && pop_class == bsl_pkg::C_GREATER)) begin
          len_nxt  = sat_inc(len_r);
          col_nxt  = sat_inc(col_r);
          r0       = mk((mode_r == M_LESS) ? bsl_pkg::K_DLESS : bsl_pkg::K_DGREATER,
                        sat_inc(len_r), tok_line_r, tok_col_r);
          n_res    = 2'd1;
          mode_nxt = M_START;
        end else begin
          // close the pending token, then let this byte start the next one
          case (mode_r)
            M_INTEGER: r0 = mk(bsl_pkg::K_INTEGER, len_r, tok_line_r, tok_col_r);
            M_LESS:    r0 = mk(bsl_pkg::K_LESS, len_r, tok_line_r, tok_col_r);
            default:   r0 = mk(bsl_pkg::K_GREATER, len_r, tok_line_r, tok_col_r);
          endcase
          r1           = sb_res;
          n_res        = sb_emit ? 2'd2 : 2'd1;
          mode_nxt     = sb_mode;
          len_nxt      = sb_len;
          line_nxt     = sb_line;
          col_nxt      = sb_col;
          tok_line_nxt = sb_tok_line;
          tok_col_nxt  = sb_tok_col;
        end
      end
      M_DROP: begin
        if (pop_class == bsl_pkg::C_NUL) begin
          mode_nxt     = M_START;
          len_nxt      = '0;
          line_nxt     = CNT_ONE;
          col_nxt      = CNT_ONE;
          tok_line_nxt = CNT_ONE;
          tok_col_nxt  = CNT_ONE;
        end
      end
      default: begin
        r0           = sb_res;
        n_res        = sb_emit ? 2'd1 : 2'd0;
        mode_nxt     = sb_mode;
        len_nxt      = sb_len;
        line_nxt     = sb_line;
        col_nxt      = sb_col;
        tok_line_nxt = sb_tok_line;
        tok_col_nxt  = sb_tok_col;
      end
    endcase
    // mark the final result of this byte
    if (n_res == 2'd2) r1.last = 1'b1;
    else r0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_START;
      len_r      <= '0;
      line_r     <= CNT_ONE;
      col_r      <= CNT_ONE;
      tok_line_r <= CNT_ONE;
      tok_col_r  <= CNT_ONE;
      cnt_r      <= 2'd0;
    end else begin
      if (pop) begin
        mode_r     <= mode_nxt;
        len_r      <= len_nxt;
        line_r     <= line_nxt;
        col_r      <= col_nxt;
        tok_line_r <= tok_line_nxt;
        tok_col_r  <= tok_col_nxt;
        // buffer is empty after this edge's drain, so results land at slot 0
        slot0_r    <= r0;
        slot1_r    <= r1;
        cnt_r      <= n_res;
      end else if (drain) begin
        slot0_r <= slot1_r;
        cnt_r   <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking testbench for byte_stream_lexer
// Feeds zero-terminated texts through the valid/ready input, tokenizes the
// same bytes in a cycle-free software lexer and checks every result beat
// field by field in order. Directed opening texts cover each token kind and
// each error path; random texts follow under three flow-control phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RUN_LIMIT   = 1_500_000;
  localparam int unsigned PHASE_ITEMS = 500;
  localparam int unsigned DRAIN_WAIT  = 8;

  // Flow-control phases
  localparam logic [1:0] PH_SLOW_SINK   = 2'd0;
  localparam logic [1:0] PH_SLOW_SOURCE = 2'd1;
  localparam logic [1:0] PH_FREE        = 2'd2;

  typedef enum logic [2:0] {
    LX_START, LX_STRING, LX_ESCAPE, LX_REGEX,
    LX_INTEGER, LX_LESS, LX_GREATER, LX_DROP
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic [1:0] phase;
    logic       drain_first;
  } text_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_token_kind;
  logic [15:0] out_token_length;
  logic [15:0] out_start_line;
  logic [15:0] out_start_column;
  logic        out_last_in_run;

  byte_stream_lexer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_length (out_token_length),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_last_in_run  (out_last_in_run)
  );

  always #10 clk = ~clk;

  text_beat_t        text_bytes_q[$];
  bsl_pkg::result_t  tokens_due[$];
  text_beat_t        next_beat;
  bsl_pkg::result_t  want;
  logic [1:0]  fill_phase = PH_SLOW_SINK;
  logic        fill_drain = 1'b0;
  logic [1:0]  cur_phase = PH_SLOW_SINK;
  logic        in_fire = 1'b0;
  logic [31:0] kinds_seen = '0;
  int unsigned stim_total = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Software lexer state
  lex_mode_t   lx_mode = LX_START;
  logic [15:0] tok_len = 16'd0;
  logic [15:0] line_no = 16'd1;
  logic [15:0] col_no = 16'd1;
  logic [15:0] tok_line = 16'd1;
  logic [15:0] tok_col = 16'd1;
  int unsigned step_results = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  function automatic logic [15:0] sat_up(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void emit_token(input logic [4:0] kind, input logic [15:0] len,
                                     input logic [15:0] ln, input logic [15:0] cl);
    bsl_pkg::result_t r;
    r.kind = kind;
    r.length = len;
    r.line = ln;
    r.column = cl;
    r.last = 1'b0;
    tokens_due.push_back(r);
    step_results++;
  endfunction

  function automatic void restart_text();
    lx_mode = LX_START;
    tok_len = 16'd0;
    line_no = 16'd1;
    col_no = 16'd1;
    tok_line = 16'd1;
    tok_col = 16'd1;
  endfunction

  function automatic void open_token(input lex_mode_t m);
    lx_mode = m;
    tok_line = line_no;
    tok_col = col_no;
    tok_len = 16'd1;
    col_no = sat_up(col_no);
  endfunction

  function automatic void extend_token();
    tok_len = sat_up(tok_len);
    col_no = sat_up(col_no);
  endfunction

  function automatic void close_token(input logic [4:0] kind);
    emit_token(kind, tok_len, tok_line, tok_col);
    lx_mode = LX_START;
  endfunction

  // Zero byte inside an open string or regex
  function automatic void fail_open_token();
    emit_token(bsl_pkg::K_ERROR, tok_len, tok_line, tok_col);
    restart_text();
  endfunction

  function automatic void begin_token(input logic [7:0] b);
    logic [4:0] kind;
    logic       single;
    kind = bsl_pkg::K_ERROR;
    single = 1'b1;
    case (b)
      bsl_pkg::CH_NUL: begin
        emit_token(bsl_pkg::K_EOF, 16'd0, line_no, col_no);
        restart_text();
        single = 1'b0;
      end
      bsl_pkg::CH_NL: begin
        emit_token(bsl_pkg::K_NEWLINE, 16'd1, line_no, col_no);
        line_no = sat_up(line_no);
        col_no = 16'd1;
        single = 1'b0;
      end
      bsl_pkg::CH_SPACE:  kind = bsl_pkg::K_SPACE;
      bsl_pkg::CH_TAB:    kind = bsl_pkg::K_TAB;
      bsl_pkg::CH_COLON:  kind = bsl_pkg::K_COLON;
      bsl_pkg::CH_POUND:  kind = bsl_pkg::K_POUND;
      bsl_pkg::CH_LPAREN: kind = bsl_pkg::K_LPAREN;
      bsl_pkg::CH_RPAREN: kind = bsl_pkg::K_RPAREN;
      bsl_pkg::CH_BAR:    kind = bsl_pkg::K_OR;
      bsl_pkg::CH_DQUOTE: begin
        open_token(LX_STRING);
        single = 1'b0;
      end
      bsl_pkg::CH_SQUOTE: begin
        open_token(LX_REGEX);
        single = 1'b0;
      end
      bsl_pkg::CH_LT: begin
        open_token(LX_LESS);
        single = 1'b0;
      end
      bsl_pkg::CH_GT: begin
        open_token(LX_GREATER);
        single = 1'b0;
      end
      default: begin
        single = 1'b0;
        if (b >= bsl_pkg::CH_ZERO && b <= bsl_pkg::CH_NINE) begin
          open_token(LX_INTEGER);
        end else begin
          emit_token(bsl_pkg::K_ERROR, 16'd1, line_no, col_no);
          lx_mode = LX_DROP;
        end
      end
    endcase
    if (single) begin
      emit_token(kind, 16'd1, line_no, col_no);
      col_no = sat_up(col_no);
    end
  endfunction

  // Tokenize one accepted byte and queue the results it causes
  function automatic void lex_byte(input logic [7:0] b);
    bsl_pkg::result_t r;
    step_results = 0;
    case (lx_mode)
      LX_STRING: begin
        if (b == bsl_pkg::CH_NUL) begin
          fail_open_token();
        end else if (b == bsl_pkg::CH_DQUOTE) begin
          extend_token();
          close_token(bsl_pkg::K_STRING);
        end else begin
          extend_token();
          if (b == bsl_pkg::CH_BSLASH) lx_mode = LX_ESCAPE;
        end
      end
      LX_ESCAPE: begin
        if (b == bsl_pkg::CH_NUL) begin
          fail_open_token();
        end else begin
          extend_token();
          lx_mode = LX_STRING;
        end
      end
      LX_REGEX: begin
        if (b == bsl_pkg::CH_NUL) begin
          fail_open_token();
        end else begin
          extend_token();
          if (b == bsl_pkg::CH_SQUOTE) close_token(bsl_pkg::K_REGEX);
        end
      end
      LX_INTEGER: begin
        if (b >= bsl_pkg::CH_ZERO && b <= bsl_pkg::CH_NINE) begin
          extend_token();
        end else begin
          close_token(bsl_pkg::K_INTEGER);
          begin_token(b);
        end
      end
      LX_LESS: begin
        if (b == bsl_pkg::CH_LT) begin
          extend_token();
          close_token(bsl_pkg::K_DLESS);
        end else begin
          close_token(bsl_pkg::K_LESS);
          begin_token(b);
        end
      end
      LX_GREATER: begin
        if (b == bsl_pkg::CH_GT) begin
          extend_token();
          close_token(bsl_pkg::K_DGREATER);
        end else begin
          close_token(bsl_pkg::K_GREATER);
          begin_token(b);
        end
      end
      LX_DROP: begin
        if (b == bsl_pkg::CH_NUL) restart_text();
      end
      default: begin
        begin_token(b);
      end
    endcase
    if (step_results != 0) begin
      r = tokens_due.pop_back();
      r.last = 1'b1;
      tokens_due.push_back(r);
    end
  endfunction

  function automatic int unsigned sender_idle_pct(input logic [1:0] ph);
    return (ph == PH_SLOW_SINK) ? 22 : (ph == PH_SLOW_SOURCE) ? 78 : 0;
  endfunction

  function automatic int unsigned sink_idle_pct(input logic [1:0] ph);
    return (ph == PH_SLOW_SINK) ? 78 : (ph == PH_SLOW_SOURCE) ? 22 : 0;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_byte(input logic [7:0] b);
    text_beat_t t;
    t.text_byte = b;
    t.phase = fill_phase;
    t.drain_first = fill_drain;
    text_bytes_q.push_back(t);
    fill_drain = 1'b0;
  endfunction

  // Random nonzero byte other than a and b
  function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    c = bsl_pkg::CH_NUL;
    while (c == bsl_pkg::CH_NUL || c == a || c == b) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] punct_byte();
    case ($urandom_range(7))
      0: return bsl_pkg::CH_NL;
      1: return bsl_pkg::CH_SPACE;
      2: return bsl_pkg::CH_TAB;
      3: return bsl_pkg::CH_LPAREN;
      4: return bsl_pkg::CH_RPAREN;
      5: return bsl_pkg::CH_COLON;
      6: return bsl_pkg::CH_POUND;
      default: return bsl_pkg::CH_BAR;
    endcase
  endfunction

  task automatic add_token();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      add_byte(8'($urandom_range(255)));
    end else if (pick < 18) begin
      repeat ($urandom_range(1, 5)) add_byte(8'(bsl_pkg::CH_ZERO + $urandom_range(9)));
    end else if (pick < 30) begin
      add_byte(bsl_pkg::CH_DQUOTE);
      repeat ($urandom_range(6)) begin
        if ($urandom_range(4) == 0) begin
          add_byte(bsl_pkg::CH_BSLASH);
          add_byte(any_but(bsl_pkg::CH_NUL, bsl_pkg::CH_NUL));
        end else begin
          add_byte(any_but(bsl_pkg::CH_DQUOTE, bsl_pkg::CH_BSLASH));
        end
      end
      add_byte(bsl_pkg::CH_DQUOTE);
    end else if (pick < 38) begin
      add_byte(bsl_pkg::CH_SQUOTE);
      repeat ($urandom_range(5)) add_byte(any_but(bsl_pkg::CH_SQUOTE, bsl_pkg::CH_SQUOTE));
      add_byte(bsl_pkg::CH_SQUOTE);
    end else if (pick < 46) begin
      add_byte(bsl_pkg::CH_LT);
      if ($urandom_range(1)) add_byte(bsl_pkg::CH_LT);
    end else if (pick < 54) begin
      add_byte(bsl_pkg::CH_GT);
      if ($urandom_range(1)) add_byte(bsl_pkg::CH_GT);
    end else begin
      add_byte(punct_byte());
    end
  endtask

  // One text: mostly well-formed tokens, sometimes left open at the zero byte
  task automatic add_text();
    int unsigned pick;
    repeat ($urandom_range(1, 10)) add_token();
    pick = $urandom_range(99);
    if (pick < 6) begin
      add_byte(bsl_pkg::CH_DQUOTE);
      repeat ($urandom_range(3)) add_byte(any_but(bsl_pkg::CH_DQUOTE, bsl_pkg::CH_BSLASH));
      if ($urandom_range(1)) add_byte(bsl_pkg::CH_BSLASH);
    end else if (pick < 12) begin
      add_byte(bsl_pkg::CH_SQUOTE);
      repeat ($urandom_range(3)) add_byte(any_but(bsl_pkg::CH_SQUOTE, bsl_pkg::CH_SQUOTE));
    end
    add_byte(bsl_pkg::CH_NUL);
  endtask

  initial begin
    string opening;
    opening = "()#:| \t\n\"\\\"\"''7<>>><<5";
    for (int i = 0; i < opening.len(); i++) add_byte(opening[i]);
    add_byte(bsl_pkg::CH_NUL);
    // Unknown byte, a dropped byte, then a silent restart
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(bsl_pkg::CH_NUL);
    // String cut off right after a backslash, then an open regex
    add_byte(bsl_pkg::CH_DQUOTE);
    add_byte(bsl_pkg::CH_BSLASH);
    add_byte(bsl_pkg::CH_NUL);
    add_byte(bsl_pkg::CH_SQUOTE);
    add_byte(bsl_pkg::CH_NUL);

    while (text_bytes_q.size() < PHASE_ITEMS) add_text();
    fill_phase = PH_SLOW_SOURCE;
    fill_drain = 1'b1;
    while (text_bytes_q.size() < 2 * PHASE_ITEMS) add_text();
    fill_phase = PH_FREE;
    fill_drain = 1'b1;
    while (text_bytes_q.size() < 3 * PHASE_ITEMS) add_text();
    stim_total = text_bytes_q.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != stim_total) @(negedge clk);
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Drove %0d text bytes across three flow-control phases, checked %0d results",
             bytes_taken, results_checked);
    $display("Saw %0d of 17 token kinds over well-formed, open and unknown-byte texts",
             $countones(kinds_seen));
    if (mismatches == 0) begin
      $display("byte_stream_lexer verification clean");
    end else begin
      $display("byte_stream_lexer verification failed");
    end
    $finish;
  end

  // ------------------------------------------------------------------ driver

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        // Hold a drain-marked beat back until every result is out
        if (text_bytes_q.size() != 0 &&
            !(text_bytes_q[0].drain_first && tokens_due.size() != 0) &&
            $urandom_range(99) >= sender_idle_pct(text_bytes_q[0].phase)) begin
          next_beat = text_bytes_q.pop_front();
          cur_phase = next_beat.phase;
          in_valid <= 1'b1;
          in_text_byte <= next_beat.text_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= sink_idle_pct(cur_phase));
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        lex_byte(in_text_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result: kind %0d len %0d at %0d:%0d",
                                    out_token_kind, out_token_length,
                                    out_start_line, out_start_column));
        end else begin
          want = tokens_due.pop_front();
          if (out_token_kind !== want.kind)
            report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                      results_checked, out_token_kind, want.kind));
          if (out_token_length !== want.length)
            report_mismatch($sformatf("result %0d length %0d, expected %0d",
                                      results_checked, out_token_length, want.length));
          if (out_start_line !== want.line)
            report_mismatch($sformatf("result %0d line %0d, expected %0d",
                                      results_checked, out_start_line, want.line));
          if (out_start_column !== want.column)
            report_mismatch($sformatf("result %0d column %0d, expected %0d",
                                      results_checked, out_start_column, want.column));
          if (out_last_in_run !== want.last)
            report_mismatch($sformatf("result %0d last flag %0b, expected %0b",
                                      results_checked, out_last_in_run, want.last));
        end
        kinds_seen[out_token_kind] = 1'b1;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               tokens_due.size());
      $display("byte_stream_lexer verification failed");
      $finish;
    end
  end

endmodule

// ----- byte_stream_lexer.f -----
sv/bsl_pkg.sv
sv/bsl_front.sv
sv/bsl_queue.sv
sv/bsl_back.sv
sv/byte_stream_lexer.sv
dv/tb.sv
